>>> rtl/core/pfrt_pkg.sv
// Package for the packet filter rule table: command and status codes,
// request/response word types, rule storage type and controller types.
// No dependencies.
package pfrt_pkg;

    localparam logic [1:0] KIND_CHECK  = 2'd0;
    localparam logic [1:0] KIND_ADD    = 2'd1;
    localparam logic [1:0] KIND_REMOVE = 2'd2;

    localparam logic [1:0] HOOK_BAD = 2'd3;

    localparam logic [1:0] PROTO_ICMP  = 2'd2;
    localparam logic [1:0] PROTO_OTHER = 2'd3;

    localparam logic [1:0] STAT_DONE      = 2'd0;
    localparam logic [1:0] STAT_FULL      = 2'd1;
    localparam logic [1:0] STAT_BAD_HOOK  = 2'd2;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  hook;
        logic [1:0]  protocol;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [31:0] src_mask;
        logic [31:0] dst_mask;
        logic [31:0] remove_id;
    } req_word_t;

    typedef struct packed {
        logic        drop;
        logic [1:0]  status;
        logic [31:0] assigned_id;
    } rsp_word_t;

    typedef struct packed {
        logic [31:0] ident;
        logic [31:0] src_addr;
        logic [31:0] src_mask;
        logic [31:0] dst_addr;
        logic [31:0] dst_mask;
        logic [15:0] src_port;
        logic [15:0] dst_port;
    } rule_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADD,
        ST_SCAN,
        ST_RESULT
    } ctrl_state_t;

    typedef struct packed {
        logic       drop;
        logic [1:0] status;
        logic       use_id;
    } res_t;

    typedef struct packed {
        logic load;
        logic step;
        logic scan;
        logic add_write;
        logic clear;
        logic out_load;
        res_t res;
    } ctrl_cmd_t;

    typedef struct packed {
        logic slot_free;
        logic at_last;
        logic hit;
        logic scan_end;
        logic out_free;
        logic is_remove;
    } dp_stat_t;

endpackage

>>> rtl/core/pfrt_ctrl.sv
// Controller state machine for the packet filter rule table.
// Depends on pfrt_pkg; drives pfrt_dp through ctrl_cmd_t, reads dp_stat_t.
module pfrt_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  logic [1:0]          req_kind,
    input  logic [1:0]          req_hook,
    input  logic [1:0]          req_proto,
    input  pfrt_pkg::dp_stat_t  stat,
    output pfrt_pkg::ctrl_cmd_t cmd
);
    import pfrt_pkg::*;

    ctrl_state_t state_reg, state_next;
    res_t        res_reg, res_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            res_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            res_reg   <= res_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    case (req_kind)
                        KIND_CHECK:
                        begin
                            if (req_hook == HOOK_BAD || req_proto == PROTO_OTHER)
                                state_next = ST_RESULT;
                            else
                                state_next = ST_SCAN;
                        end
                        KIND_ADD:
                        begin
                            if (req_hook == HOOK_BAD)
                                state_next = ST_RESULT;
                            else
                                state_next = ST_ADD;
                        end
                        KIND_REMOVE: state_next = ST_SCAN;
                        default:     state_next = ST_RESULT;
                    endcase
                end
            end
            ST_ADD:
            begin
                if (stat.slot_free || stat.at_last)
                    state_next = ST_RESULT;
            end
            ST_SCAN:
            begin
                if (stat.hit || stat.scan_end)
                    state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (stat.out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd       = '0;
        res_next  = res_reg;
        req_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load = 1'b1;
                    case (req_kind)
                        KIND_CHECK:
                        begin
                            if (req_hook == HOOK_BAD)
                                res_next = '{drop: 1'b0, status: STAT_BAD_HOOK, use_id: 1'b0};
                            else if (req_proto == PROTO_OTHER)
                                res_next = '{drop: 1'b1, status: STAT_DONE, use_id: 1'b0};
                        end
                        KIND_ADD:
                        begin
                            if (req_hook == HOOK_BAD)
                                res_next = '{drop: 1'b0, status: STAT_BAD_HOOK, use_id: 1'b0};
                        end
                        KIND_REMOVE: ;
                        default:
                            res_next = '{drop: 1'b0, status: STAT_DONE, use_id: 1'b0};
                    endcase
                end
            end
            ST_ADD:
            begin
                if (stat.slot_free)
                begin
                    cmd.add_write = 1'b1;
                    res_next = '{drop: 1'b0, status: STAT_DONE, use_id: 1'b1};
                end
                else if (stat.at_last)
                    res_next = '{drop: 1'b0, status: STAT_FULL, use_id: 1'b0};
                else
                    cmd.step = 1'b1;
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                cmd.step = 1'b1;
                if (stat.hit)
                begin
                    cmd.clear = stat.is_remove;
                    res_next  = '{drop: !stat.is_remove, status: STAT_DONE, use_id: 1'b0};
                end
                else if (stat.scan_end)
                begin
                    if (stat.is_remove)
                        res_next = '{drop: 1'b0, status: STAT_NOT_FOUND, use_id: 1'b0};
                    else
                        res_next = '{drop: 1'b0, status: STAT_DONE, use_id: 1'b0};
                end
            end
            ST_RESULT:
            begin
                cmd.res = res_reg;
                if (stat.out_free)
                    cmd.out_load = 1'b1;
            end
            default: ;
        endcase
    end

endmodule

>>> rtl/core/pfrt_dp.sv
// Datapath for the packet filter rule table: rule memory, valid bits,
// slot counter, match logic, id counter and response register.
// Depends on pfrt_pkg; commanded by pfrt_ctrl.
module pfrt_dp #(
    parameter int RULES_PER_HOOK = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  pfrt_pkg::req_word_t req,
    input  pfrt_pkg::ctrl_cmd_t cmd,
    output pfrt_pkg::dp_stat_t  stat,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output pfrt_pkg::rsp_word_t rsp
);
    import pfrt_pkg::*;

    localparam int SLOTS = 3 * RULES_PER_HOOK;
    localparam int AW    = $clog2(SLOTS);
    localparam logic [AW-1:0] HOOK_SPAN = AW'(RULES_PER_HOOK);
    localparam logic [AW-1:0] SPAN_LAST = AW'(RULES_PER_HOOK - 1);
    localparam logic [AW-1:0] SLOT_LAST = AW'(SLOTS - 1);

    rule_t mem [SLOTS];

    req_word_t       item_reg;
    logic [AW-1:0]   cnt_reg, cnt_next;
    logic [AW-1:0]   last_reg, last_next;
    logic [SLOTS-1:0] valid_reg, valid_next;
    rule_t           rd_rule_reg;
    logic [AW-1:0]   rd_addr_reg;
    logic            rd_valid_reg;
    logic            rd_last_reg;
    logic            rd_live_reg, rd_live_next;
    logic [31:0]     next_ident_reg, next_ident_next;
    logic [31:0]     assigned_reg;
    logic            rsp_valid_reg, rsp_valid_next;
    rsp_word_t       rsp_reg;

    logic [AW-1:0] base;
    logic          req_remove;
    logic          addr_hit, port_hit, rule_hit;
    rule_t         new_rule;

    assign base       = AW'(req.hook) * HOOK_SPAN;
    assign req_remove = (req.kind == KIND_REMOVE);

    always_comb
    begin
        cnt_next  = cnt_reg;
        last_next = last_reg;
        if (cmd.load)
        begin
            cnt_next  = req_remove ? '0 : base;
            last_next = req_remove ? SLOT_LAST : base + SPAN_LAST;
        end
        else if (cmd.step && cnt_reg != last_reg)
            cnt_next = cnt_reg + AW'(1);
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.add_write)
            valid_next[cnt_reg] = 1'b1;
        if (cmd.clear)
            valid_next[rd_addr_reg] = 1'b0;
    end

    assign rd_live_next    = cmd.scan;
    assign next_ident_next = cmd.add_write ? next_ident_reg + 32'd1 : next_ident_reg;
    assign rsp_valid_next  = cmd.out_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_reg);

    assign new_rule = '{
        ident:    next_ident_reg,
        src_addr: item_reg.src_addr,
        src_mask: item_reg.src_mask,
        dst_addr: item_reg.dst_addr,
        dst_mask: item_reg.dst_mask,
        src_port: item_reg.src_port,
        dst_port: item_reg.dst_port
    };

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= '0;
            last_reg       <= '0;
            valid_reg      <= '0;
            rd_live_reg    <= 1'b0;
            next_ident_reg <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg        <= cnt_next;
            last_reg       <= last_next;
            valid_reg      <= valid_next;
            rd_live_reg    <= rd_live_next;
            next_ident_reg <= next_ident_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.add_write)
            mem[cnt_reg] <= new_rule;
        rd_rule_reg <= mem[cnt_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            item_reg <= req;
        if (cmd.add_write)
            assigned_reg <= next_ident_reg;
        rd_addr_reg  <= cnt_reg;
        rd_valid_reg <= valid_reg[cnt_reg];
        rd_last_reg  <= (cnt_reg == last_reg);
        if (cmd.out_load)
        begin
            rsp_reg.drop        <= cmd.res.drop;
            rsp_reg.status      <= cmd.res.status;
            rsp_reg.assigned_id <= cmd.res.use_id ? assigned_reg : 32'd0;
        end
    end

    assign addr_hit =
        ((rd_rule_reg.dst_addr & rd_rule_reg.dst_mask) ==
         (item_reg.dst_addr & rd_rule_reg.dst_mask)) &&
        ((rd_rule_reg.src_addr & rd_rule_reg.src_mask) ==
         (item_reg.src_addr & rd_rule_reg.src_mask));

    assign port_hit =
        (rd_rule_reg.dst_port == 16'd0 || rd_rule_reg.dst_port == item_reg.dst_port) &&
        (rd_rule_reg.src_port == 16'd0 || rd_rule_reg.src_port == item_reg.src_port);

    always_comb
    begin
        if (item_reg.kind == KIND_REMOVE)
            rule_hit = (rd_rule_reg.ident == item_reg.remove_id);
        else
            rule_hit = addr_hit && (item_reg.protocol == PROTO_ICMP || port_hit);
    end

    assign stat.slot_free = !valid_reg[cnt_reg];
    assign stat.at_last   = (cnt_reg == last_reg);
    assign stat.hit       = rd_live_reg && rd_valid_reg && rule_hit;
    assign stat.scan_end  = rd_live_reg && rd_last_reg;
    assign stat.out_free  = !rsp_valid_reg || rsp_ready;
    assign stat.is_remove = (item_reg.kind == KIND_REMOVE);

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

>>> rtl/core/packet_filter_rule_table_unit.sv
// Packet filter rule table, top level: three masked five-tuple rule tables
// (input, forward, output) with add, remove and check. Holds pfrt_ctrl and
// pfrt_dp; depends on pfrt_pkg.
//
// One request word at a time. A check walks the chosen table one rule per
// cycle through the registered rule memory read port, stopping at the first
// match. An add walks the valid bits of the chosen table. A remove walks all
// 3 * RULES_PER_HOOK slots. A bad hook point on a check or add, an unknown
// protocol on a check, or an unused kind answers without a walk. The
// response register frees the next request while a response waits. Valid
// bits clear at reset; no clearing pass.
module packet_filter_rule_table_unit #(
    parameter int RULES_PER_HOOK = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  pfrt_pkg::req_word_t req,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output pfrt_pkg::rsp_word_t rsp
);
    import pfrt_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    pfrt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_kind  (req.kind),
        .req_hook  (req.hook),
        .req_proto (req.protocol),
        .stat      (stat),
        .cmd       (cmd)
    );

    pfrt_dp #(
        .RULES_PER_HOOK (RULES_PER_HOOK)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule
